// ----- design/sil_pkg.sv -----
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted insert list block: field widths,
// command and status codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sil_pkg;

    // field widths of the request and result items
    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic                load;        // capture a new request
        logic                set_status;  // latch result status
        logic [STATUS_W-1:0] status;
        logic                rd_last;     // read last entry, point at it
        logic                walk;        // shift one entry up and step down, or place value
        logic                place_zero;  // write new value at rank zero
        logic                finish;      // bump the entry count
        logic                out_load;    // move result into output stage
    } sil_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_read;
        logic full;
        logic empty;
        logic rank_ok;
        logic ptr_zero;
        logic shift;
    } sil_stat_t;

endpackage

// ----- design/sorted_insert_list_top.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_list_top
// Bounded multiset of signed 32-bit values kept in ascending order, with
// ordered insert and read-by-rank requests.
//
//   channel  | dir | tdata fields (low to high)             | tuser
//   s_axis   | in  | value[31:0] rank[37:32]                | command
//   m_axis   | out | read_value[31:0] status[33:32]         | -
//            |     | count[40:34]                           |
//
// A read or a dropped insert goes from the start state to the result state.
// An insert on an empty store writes its value straight at rank zero; else
// the walk moves one stored entry per cycle through the single write port
// of the entry memory, from the top down to the slot.
// Of the stored data, reset clears the entry count only; the entry memory needs no clearing.
// One request is in flight at a time; the next request is taken while a
// result still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_insert_list_top #(
    parameter int DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sil_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // value, rank
    input  logic                               s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sil_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // read_value, status, count
);

    sil_pkg::sil_cmd_t             cmd;
    sil_pkg::sil_stat_t            stat;
    logic [sil_pkg::VALUE_W-1:0]   out_read_value;
    logic [sil_pkg::STATUS_W-1:0]  out_status;
    logic [sil_pkg::COUNT_W-1:0]   out_count;

    // sequencer
    sil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    sil_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_command     (s_axis_tuser),
        .in_value       (s_axis_tdata[31:0]),
        .in_rank        (s_axis_tdata[37:32]),
        .cmd            (cmd),
        .stat           (stat),
        .out_read_value (out_read_value),
        .out_status     (out_status),
        .out_count      (out_count)
    );

    // result packing
    assign m_axis_tdata = {7'b0, out_count, out_status, out_read_value};

    // a dropped insert only happens on a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status == sil_pkg::ST_FULL)
            |-> (out_count == sil_pkg::COUNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // a failed request never carries data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status != sil_pkg::ST_OK) |-> (out_read_value == '0))
        else $error("nonzero read value on error status");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // the walk never starts on an empty or full store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_last |-> (!stat.empty && !stat.full))
        else $error("walk started on empty or full store");

endmodule

// ----- design/sil_ram.sv -----
// ----------------------------------------------------------------------------
// sil_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sil_ctrl.sv -----
// ----------------------------------------------------------------------------
// sil_ctrl
// Sequencer for the sorted insert list: accepts a request, walks the stored
// entries from the top down for an insert, and hands the result to the
// output stage.
// ----------------------------------------------------------------------------
module sil_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sil_pkg::sil_stat_t  stat,
    output sil_pkg::sil_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = sil_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.set_status = 1'b1;
                if (stat.is_read)
                begin
                    cmd.status = stat.rank_ok ? sil_pkg::ST_OK : sil_pkg::ST_RANGE;
                    state_next = S_RESULT;
                end
                else if (stat.full)
                begin
                    cmd.status = sil_pkg::ST_FULL;
                    state_next = S_RESULT;
                end
                else if (stat.empty)
                begin
                    cmd.place_zero = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (!stat.shift)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESULT;
                end
                else if (stat.ptr_zero)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place_zero = 1'b1;
                cmd.finish     = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/sil_dp.sv -----
// ----------------------------------------------------------------------------
// sil_dp
// Datapath for the sorted insert list: request registers, entry count, walk
// pointer, entry memory, and the output register stage.
// ----------------------------------------------------------------------------
module sil_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_command,
    input  logic [sil_pkg::VALUE_W-1:0]          in_value,
    input  logic [sil_pkg::RANK_W-1:0]           in_rank,
    input  sil_pkg::sil_cmd_t                    cmd,
    output sil_pkg::sil_stat_t                   stat,
    output logic [sil_pkg::VALUE_W-1:0]          out_read_value,
    output logic [sil_pkg::STATUS_W-1:0]         out_status,
    output logic [sil_pkg::COUNT_W-1:0]          out_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > sil_pkg::RANK_W) ? CW : sil_pkg::RANK_W;

    logic                          command_reg;
    logic [sil_pkg::VALUE_W-1:0]   value_reg;
    logic [sil_pkg::RANK_W-1:0]    rank_reg;
    logic [sil_pkg::STATUS_W-1:0]  status_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [AW-1:0]                 ptr_reg;
    logic [AW-1:0]                 ptr_next;
    logic [sil_pkg::VALUE_W-1:0]   res_value_reg;
    logic [sil_pkg::STATUS_W-1:0]  res_status_reg;
    logic [sil_pkg::COUNT_W-1:0]   res_count_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [sil_pkg::VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [sil_pkg::VALUE_W-1:0]   ram_rdata;

    // status toward the controller
    assign stat.is_read  = (command_reg == sil_pkg::CMD_READ);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.rank_ok  = (CMP_W'(rank_reg) < CMP_W'(count_reg));
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.shift    = ($signed(ram_rdata) >= $signed(value_reg));

    // memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg + AW'(1);
        ram_wdata = value_reg;
        ram_raddr = AW'(rank_reg);
        if (cmd.walk)
        begin
            ram_we    = 1'b1;
            ram_wdata = stat.shift ? ram_rdata : value_reg;
            ram_raddr = ptr_reg - AW'(1);
        end
        else if (cmd.place_zero)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
        end
        else if (cmd.rd_last)
        begin
            ram_raddr = AW'(count_reg - CW'(1));
        end
    end

    sil_ram #(
        .WIDTH (sil_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pointer and count updates
    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        if (cmd.rd_last)
        begin
            ptr_next = AW'(count_reg - CW'(1));
        end
        else if (cmd.walk && stat.shift)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
        if (cmd.finish)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // request, pointer and result registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            command_reg <= in_command;
            value_reg   <= in_value;
            rank_reg    <= in_rank;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.out_load)
        begin
            res_status_reg <= status_reg;
            res_count_reg  <= sil_pkg::COUNT_W'(count_reg);
            res_value_reg  <= (stat.is_read && status_reg == sil_pkg::ST_OK) ?
                              ram_rdata : '0;
        end
    end

    assign out_read_value = res_value_reg;
    assign out_status     = res_status_reg;
    assign out_count      = res_count_reg;

endmodule
